### rtl/relt_pkg.sv
// Shared types and codes of the range entry linked table.
package relt_pkg;

  localparam int ADDR_BITS = 64;
  localparam int TAG_IN_BITS = 16;
  localparam int SLOT_BITS = 6;
  localparam int IN_DATA_BITS = 296;
  localparam int OUT_DATA_BITS = 232;

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_FIND   = 2'd1,
    MODE_REMOVE = 2'd2,
    MODE_CLEAR  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_FULL     = 2'd1,
    STAT_NO_MATCH = 2'd2,
    STAT_NOT_LIVE = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_SWEEP,
    CMD_INS_RD,
    CMD_INS_LINK,
    CMD_INS_TAIL,
    CMD_FND_RD,
    CMD_FND_NEXT,
    CMD_REM_RD,
    CMD_REM_UNLINK,
    CMD_REM_SELF,
    CMD_REM_FREE,
    CMD_EMIT
  } cmd_t;

  typedef enum logic [3:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_INS_RD,
    ST_INS_LINK,
    ST_INS_TAIL,
    ST_FND_RD,
    ST_FND_CMP,
    ST_REM_RD,
    ST_REM_UNLINK,
    ST_REM_SELF,
    ST_REM_FREE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    cmd_t    cmd;
    status_t res;
  } ctl_t;

  typedef struct packed {
    logic full;
    logic hit;
    logic cur_nil;
    logic steps_done;
    logic slot_live;
    logic slot_oob;
    logic sweep_done;
    logic out_busy;
  } sts_t;

endpackage

### rtl/range_entry_linked_table_top.sv
// Top level of the range entry linked table.
// The table holds DEPTH address-range records threaded by a live list and a
// free list, and answers each request with exactly one response. After reset,
// and for a clear request, the link memories are rebuilt one slot a cycle,
// and no request is taken until the rebuild is done. An insert steps through
// read, link and tail states and a remove through read, unlink, self and free
// states, limited by the single write port of the link memories; a find
// visits the live records one by one, oldest first, since each step waits on
// the registered read of the next link. A finished response waits in an
// output register while the next request is taken.
module range_entry_linked_table_top #(
  parameter int DEPTH = 64,
  parameter int TAG_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // range_start, range_end, fetch_origin, alloc_tag, handle_tag,
  // probe_address, slot_in, zero fill.
  input  logic [relt_pkg::IN_DATA_BITS-1:0]   s_tdata,
  // mode.
  input  logic [1:0]                          s_tuser,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // slot_out, rec_start, rec_end, rec_origin, rec_alloc, rec_handle, zero fill.
  output logic [relt_pkg::OUT_DATA_BITS-1:0]  m_tdata,
  // status.
  output logic [1:0]                          m_tuser
);
  import relt_pkg::*;

  ctl_t  ctl;
  sts_t  sts;
  mode_t mode;

  assign mode = mode_t'(s_tuser);

  relt_ctrl u_ctrl (
    .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .mode(mode), .sts(sts), .ctl(ctl)
  );

  relt_dp #(.DEPTH(DEPTH), .TAG_BITS(TAG_BITS)) u_dp (
    .clk(clk), .rst(rst), .ctl(ctl), .sts(sts), .s_tdata(s_tdata),
    .s_mode(mode), .m_tvalid(m_tvalid), .m_tready(m_tready),
    .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  a_sweep_after_reset: assert property (@(posedge clk) rst |=> !s_tready)
    else $error("request taken during the rebuild after reset");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second request taken before the first was answered");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    ctl.cmd == CMD_EMIT |-> !sts.out_busy)
    else $error("response written over one not yet taken");

  a_no_insert_full: assert property (@(posedge clk) disable iff (rst)
    ctl.cmd == CMD_INS_RD |-> !sts.full)
    else $error("insert started on a full table");

endmodule

### rtl/relt_ram.sv
// Generic simple dual-port RAM with registered read.
module relt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/relt_ctrl.sv
// Controller state machine sequencing each request over the datapath.
module relt_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  relt_pkg::mode_t  mode,
  input  relt_pkg::sts_t   sts,
  output relt_pkg::ctl_t   ctl
);
  import relt_pkg::*;

  state_t  state, state_next;
  status_t rstat, rstat_next;
  logic    reply, reply_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_SWEEP;
      rstat <= STAT_OK;
      reply <= 1'b0;
    end else begin
      state <= state_next;
      rstat <= rstat_next;
      reply <= reply_next;
    end
  end

  always_comb begin
    state_next = state;
    rstat_next = rstat;
    reply_next = reply;
    unique case (state)
      ST_SWEEP: begin
        if (sts.sweep_done) begin
          rstat_next = STAT_OK;
          state_next = reply ? ST_EMIT : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (s_tvalid) begin
          unique case (mode)
            MODE_INSERT: state_next = ST_INS_RD;
            MODE_FIND:   state_next = ST_FND_RD;
            MODE_REMOVE: state_next = ST_REM_RD;
            MODE_CLEAR: begin
              state_next = ST_SWEEP;
              reply_next = 1'b1;
            end
            default: state_next = ST_IDLE;
          endcase
        end
      end
      ST_INS_RD: begin
        if (sts.full) begin
          rstat_next = STAT_FULL;
          state_next = ST_EMIT;
        end else begin
          state_next = ST_INS_LINK;
        end
      end
      ST_INS_LINK: state_next = ST_INS_TAIL;
      ST_INS_TAIL: begin
        rstat_next = STAT_OK;
        state_next = ST_EMIT;
      end
      ST_FND_RD: begin
        if (sts.cur_nil || sts.steps_done) begin
          rstat_next = STAT_NO_MATCH;
          state_next = ST_EMIT;
        end else begin
          state_next = ST_FND_CMP;
        end
      end
      ST_FND_CMP: begin
        if (sts.hit) begin
          rstat_next = STAT_OK;
          state_next = ST_EMIT;
        end else begin
          state_next = ST_FND_RD;
        end
      end
      ST_REM_RD: begin
        if (sts.slot_oob) begin
          rstat_next = STAT_NOT_LIVE;
          state_next = ST_EMIT;
        end else begin
          state_next = ST_REM_UNLINK;
        end
      end
      ST_REM_UNLINK: begin
        if (!sts.slot_live) begin
          rstat_next = STAT_NOT_LIVE;
          state_next = ST_EMIT;
        end else begin
          state_next = ST_REM_SELF;
        end
      end
      ST_REM_SELF: state_next = ST_REM_FREE;
      ST_REM_FREE: begin
        rstat_next = STAT_OK;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (!sts.out_busy) begin
          reply_next = 1'b0;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready = 1'b0;
    ctl.cmd  = CMD_NONE;
    ctl.res  = rstat;
    unique case (state)
      ST_SWEEP: ctl.cmd = CMD_SWEEP;
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          ctl.cmd = CMD_LOAD;
        end
      end
      ST_INS_RD: begin
        if (!sts.full) begin
          ctl.cmd = CMD_INS_RD;
        end
      end
      ST_INS_LINK: ctl.cmd = CMD_INS_LINK;
      ST_INS_TAIL: ctl.cmd = CMD_INS_TAIL;
      ST_FND_RD: begin
        if (!(sts.cur_nil || sts.steps_done)) begin
          ctl.cmd = CMD_FND_RD;
        end
      end
      ST_FND_CMP: begin
        if (!sts.hit) begin
          ctl.cmd = CMD_FND_NEXT;
        end
      end
      ST_REM_RD: begin
        if (!sts.slot_oob) begin
          ctl.cmd = CMD_REM_RD;
        end
      end
      ST_REM_UNLINK: begin
        if (sts.slot_live) begin
          ctl.cmd = CMD_REM_UNLINK;
        end
      end
      ST_REM_SELF: ctl.cmd = CMD_REM_SELF;
      ST_REM_FREE: ctl.cmd = CMD_REM_FREE;
      ST_EMIT: begin
        if (!sts.out_busy) begin
          ctl.cmd = CMD_EMIT;
        end
      end
      default: ctl.cmd = CMD_NONE;
    endcase
  end

endmodule

### rtl/relt_dp.sv
// Datapath holding the slot memories, list pointers and output register.
module relt_dp #(
  parameter int DEPTH = 64,
  parameter int TAG_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  relt_pkg::ctl_t                      ctl,
  output relt_pkg::sts_t                      sts,
  input  logic [relt_pkg::IN_DATA_BITS-1:0]   s_tdata,
  input  relt_pkg::mode_t                     s_mode,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [relt_pkg::OUT_DATA_BITS-1:0]  m_tdata,
  output logic [1:0]                          m_tuser
);
  import relt_pkg::*;

  localparam int SW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LW = $clog2(DEPTH + 1);
  localparam int RW = 3 * ADDR_BITS + 2 * TAG_BITS;
  localparam logic [LW-1:0] NIL = LW'(DEPTH);
  localparam logic [SW-1:0] LAST = SW'(DEPTH - 1);

  mode_t                 mode;
  logic [ADDR_BITS-1:0]  q_start, q_end, q_origin, q_probe;
  logic [TAG_IN_BITS-1:0] q_alloc, q_handle;
  logic [SLOT_BITS-1:0]  q_slot;

  logic [LW-1:0] free_head, free_tail, live_head, live_tail, live_count;
  logic [LW-1:0] cur, steps;
  logic [SW-1:0] idx, res_slot;

  logic [LW-1:0] free_head_next, free_tail_next, live_head_next, live_tail_next;
  logic [LW-1:0] live_count_next, cur_next, steps_next;
  logic [SW-1:0] idx_next, res_slot_next;

  logic          nx_we, nx_re, pv_we, pv_re, lv_we, lv_re, rc_we, rc_re;
  logic [SW-1:0] nx_waddr, nx_raddr, pv_waddr, pv_raddr, lv_waddr, lv_raddr;
  logic [SW-1:0] rc_waddr, rc_raddr;
  logic [LW-1:0] nx_wdata, nx_rdata, pv_wdata, pv_rdata;
  logic          lv_wdata, lv_rdata;
  logic [RW-1:0] rc_wdata, rc_rdata;

  logic [ADDR_BITS-1:0] r_start, r_end, r_origin;
  logic [TAG_BITS-1:0]  r_alloc, r_handle;
  logic [SW-1:0]        rm_slot;
  logic                 out_valid;
  logic [OUT_DATA_BITS-1:0] out_data;
  status_t              out_stat;

  relt_ram #(.WIDTH(LW), .DEPTH(DEPTH)) u_next (
    .clk(clk), .we(nx_we), .waddr(nx_waddr), .wdata(nx_wdata),
    .re(nx_re), .raddr(nx_raddr), .rdata(nx_rdata)
  );
  relt_ram #(.WIDTH(LW), .DEPTH(DEPTH)) u_prev (
    .clk(clk), .we(pv_we), .waddr(pv_waddr), .wdata(pv_wdata),
    .re(pv_re), .raddr(pv_raddr), .rdata(pv_rdata)
  );
  relt_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_live (
    .clk(clk), .we(lv_we), .waddr(lv_waddr), .wdata(lv_wdata),
    .re(lv_re), .raddr(lv_raddr), .rdata(lv_rdata)
  );
  relt_ram #(.WIDTH(RW), .DEPTH(DEPTH)) u_rec (
    .clk(clk), .we(rc_we), .waddr(rc_waddr), .wdata(rc_wdata),
    .re(rc_re), .raddr(rc_raddr), .rdata(rc_rdata)
  );

  assign r_start  = rc_rdata[ADDR_BITS-1:0];
  assign r_end    = rc_rdata[2*ADDR_BITS-1:ADDR_BITS];
  assign r_origin = rc_rdata[3*ADDR_BITS-1:2*ADDR_BITS];
  assign r_alloc  = rc_rdata[3*ADDR_BITS+TAG_BITS-1:3*ADDR_BITS];
  assign r_handle = rc_rdata[RW-1:3*ADDR_BITS+TAG_BITS];
  assign rm_slot  = SW'(q_slot);

  always_comb begin
    sts.full       = (live_count == NIL);
    sts.hit        = (r_start <= q_probe) && (q_probe < r_end);
    sts.cur_nil    = (cur == NIL);
    sts.steps_done = (steps == NIL);
    sts.slot_live  = lv_rdata;
    sts.slot_oob   = ({26'd0, q_slot} >= 32'(DEPTH));
    sts.sweep_done = (idx == LAST);
    sts.out_busy   = out_valid && !m_tready;
  end

  always_comb begin
    free_head_next  = free_head;
    free_tail_next  = free_tail;
    live_head_next  = live_head;
    live_tail_next  = live_tail;
    live_count_next = live_count;
    cur_next        = cur;
    steps_next      = steps;
    idx_next        = idx;
    res_slot_next   = res_slot;
    nx_we = 1'b0; nx_re = 1'b0; nx_waddr = '0; nx_raddr = '0; nx_wdata = NIL;
    pv_we = 1'b0; pv_re = 1'b0; pv_waddr = '0; pv_raddr = '0; pv_wdata = NIL;
    lv_we = 1'b0; lv_re = 1'b0; lv_waddr = '0; lv_raddr = '0; lv_wdata = 1'b0;
    rc_we = 1'b0; rc_re = 1'b0; rc_waddr = res_slot; rc_raddr = '0;
    rc_wdata = {TAG_BITS'(q_handle), TAG_BITS'(q_alloc), q_origin, q_end, q_start};
    unique case (ctl.cmd)
      CMD_SWEEP: begin
        nx_we = 1'b1; nx_waddr = idx;
        nx_wdata = (idx == LAST) ? NIL : LW'(idx) + LW'(1);
        pv_we = 1'b1; pv_waddr = idx;
        pv_wdata = (idx == '0) ? NIL : LW'(idx) - LW'(1);
        lv_we = 1'b1; lv_waddr = idx;
        idx_next = (idx == LAST) ? '0 : idx + SW'(1);
        free_head_next  = '0;
        free_tail_next  = LW'(DEPTH - 1);
        live_head_next  = NIL;
        live_tail_next  = NIL;
        live_count_next = '0;
      end
      CMD_LOAD: begin
        cur_next   = live_head;
        steps_next = '0;
      end
      CMD_INS_RD: begin
        nx_re = 1'b1; nx_raddr = free_head[SW-1:0];
        res_slot_next = free_head[SW-1:0];
      end
      CMD_INS_LINK: begin
        pv_we = (nx_rdata != NIL); pv_waddr = nx_rdata[SW-1:0];
        nx_we = 1'b1; nx_waddr = res_slot;
        lv_we = 1'b1; lv_waddr = res_slot; lv_wdata = 1'b1;
        rc_we = 1'b1;
      end
      CMD_INS_TAIL: begin
        pv_we = 1'b1; pv_waddr = res_slot; pv_wdata = live_tail;
        nx_we = (live_tail != NIL); nx_waddr = live_tail[SW-1:0];
        nx_wdata = LW'(res_slot);
        free_head_next = nx_rdata;
        if (nx_rdata == NIL) begin
          free_tail_next = NIL;
        end
        if (live_tail == NIL) begin
          live_head_next = LW'(res_slot);
        end
        live_tail_next  = LW'(res_slot);
        live_count_next = live_count + LW'(1);
      end
      CMD_FND_RD: begin
        rc_re = 1'b1; rc_raddr = cur[SW-1:0];
        nx_re = 1'b1; nx_raddr = cur[SW-1:0];
        res_slot_next = cur[SW-1:0];
      end
      CMD_FND_NEXT: begin
        cur_next   = nx_rdata;
        steps_next = steps + LW'(1);
      end
      CMD_REM_RD: begin
        rc_re = 1'b1; rc_raddr = rm_slot;
        nx_re = 1'b1; nx_raddr = rm_slot;
        pv_re = 1'b1; pv_raddr = rm_slot;
        lv_re = 1'b1; lv_raddr = rm_slot;
        res_slot_next = rm_slot;
      end
      CMD_REM_UNLINK: begin
        nx_we = (pv_rdata != NIL); nx_waddr = pv_rdata[SW-1:0]; nx_wdata = nx_rdata;
        pv_we = (nx_rdata != NIL); pv_waddr = nx_rdata[SW-1:0]; pv_wdata = pv_rdata;
        lv_we = 1'b1; lv_waddr = res_slot;
        if (pv_rdata == NIL) begin
          live_head_next = nx_rdata;
        end
        if (nx_rdata == NIL) begin
          live_tail_next = pv_rdata;
        end
      end
      CMD_REM_SELF: begin
        nx_we = 1'b1; nx_waddr = res_slot;
        pv_we = 1'b1; pv_waddr = res_slot; pv_wdata = free_tail;
      end
      CMD_REM_FREE: begin
        nx_we = (free_tail != NIL); nx_waddr = free_tail[SW-1:0];
        nx_wdata = LW'(res_slot);
        if (free_tail == NIL) begin
          free_head_next = LW'(res_slot);
        end
        free_tail_next = LW'(res_slot);
        if (live_count != '0) begin
          live_count_next = live_count - LW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_stat = ctl.res;
    out_data = '0;
    if (out_stat == STAT_OK && (mode == MODE_FIND || mode == MODE_REMOVE)) begin
      out_data = {2'd0, TAG_IN_BITS'(r_handle), TAG_IN_BITS'(r_alloc),
                  r_origin, r_end, r_start, SLOT_BITS'(res_slot)};
    end else if (out_stat == STAT_OK && mode == MODE_INSERT) begin
      out_data[SLOT_BITS-1:0] = SLOT_BITS'(res_slot);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      free_head  <= '0;
      free_tail  <= LW'(DEPTH - 1);
      live_head  <= NIL;
      live_tail  <= NIL;
      live_count <= '0;
      cur        <= NIL;
      steps      <= '0;
      idx        <= '0;
      res_slot   <= '0;
      out_valid  <= 1'b0;
    end else begin
      free_head  <= free_head_next;
      free_tail  <= free_tail_next;
      live_head  <= live_head_next;
      live_tail  <= live_tail_next;
      live_count <= live_count_next;
      cur        <= cur_next;
      steps      <= steps_next;
      idx        <= idx_next;
      res_slot   <= res_slot_next;
      if (ctl.cmd == CMD_EMIT) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.cmd == CMD_LOAD) begin
      mode     <= s_mode;
      q_start  <= s_tdata[63:0];
      q_end    <= s_tdata[127:64];
      q_origin <= s_tdata[191:128];
      q_alloc  <= s_tdata[207:192];
      q_handle <= s_tdata[223:208];
      q_probe  <= s_tdata[287:224];
      q_slot   <= s_tdata[293:288];
    end
    if (ctl.cmd == CMD_EMIT) begin
      m_tdata <= out_data;
      m_tuser <= out_stat;
    end
  end

  assign m_tvalid = out_valid;

endmodule
